>>> hdl/sbd_pkg.sv
package sbd_pkg;

  localparam int WORD_W = 64;
  localparam int CODE_W = 8;
  localparam int NUM_CODES = WORD_W / CODE_W;
  localparam int POS_W = $clog2(NUM_CODES) + 1;

  localparam logic [CODE_W-1:0] CODE_END     = 8'd252;
  localparam logic [CODE_W-1:0] CODE_RAW     = 8'd253;
  localparam logic [CODE_W-1:0] CODE_SPACES  = 8'd254;
  localparam logic [CODE_W-1:0] CODE_MISSING = 8'd255;
  localparam logic [CODE_W-1:0] CODE_NONE    = 8'd0;
  localparam logic [CODE_W-1:0] CODE_BIAS    = 8'd100;

  localparam logic [WORD_W-1:0] SPACES_WORD = 64'h2020_2020_2020_2020;

  // Binary64 pattern of (code - 100); magnitude is at most 151, so 8 bits.
  function automatic logic [WORD_W-1:0] code_to_double(input logic [CODE_W-1:0] code);
    logic         neg;
    logic [7:0]   mag;
    logic [2:0]   e;
    logic [51:0]  frac;
    logic [10:0]  bexp;
    neg  = (code < CODE_BIAS);
    mag  = neg ? (CODE_BIAS - code) : (code - CODE_BIAS);
    e    = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (mag[i]) e = 3'(i);
    end
    frac = {44'd0, mag << (4'd8 - {1'b0, e})} << 44;
    bexp = 11'd1023 + {8'd0, e};
    if (mag == 8'd0) code_to_double = '0;
    else code_to_double = {neg, bexp, frac};
  endfunction

endpackage

>>> hdl/sav_bytecode_decompressor.sv
// SPSS .sav bytecode decompressor.
// Input channel in_valid/in_ready carries in_word, 64 bits of the compressed
// stream with byte 0 in bits 7:0. Output channel out_valid/out_ready carries
// out_word, item_kind (1 = end marker) and last (final result until next input).
// missing_word is written through cfg_we/cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// A control word is taken and then walked one code byte per cycle while the
// receiver does not stall, by shifting it down eight bits at a time; a 253
// pauses the walk for a data word and a 252 ends it. Each result is registered.
// A data word following code 253 gives its result in the cycle after its
// transfer, and the walk of the held control block resumes the next cycle.
// The output register holds one result; while the receiver stalls the walk
// holds at a code that gives a result, and input is taken only when the walk
// is done or waits for a data word and the output register is free.
// Reset clears the state to "awaiting a control block", clears the end flag
// and sets missing_word to zero. After code 252 every later input word is
// accepted and dropped.
module sav_bytecode_decompressor
  import sbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_word,
  output logic              item_kind,
  output logic              last,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_WALK} state_t;

  state_t            state;
  logic [WORD_W-1:0] codes;       // shifts down one code per step
  logic [POS_W-1:0]  left;        // codes remaining in the shift register
  logic              ended;
  logic [WORD_W-1:0] missing_word;

  logic [CODE_W-1:0] code;
  logic              out_free;
  logic              out_load;
  logic              more_after;

  assign code     = codes[CODE_W-1:0];
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign out_load = ((state == S_IDLE) && in_valid && in_ready && !ended && (left != '0)) ||
                    ((state == S_WALK) && (code != CODE_RAW) && (code != CODE_NONE) &&
                     out_free);

  // another result follows from the codes above this one before the next raw code
  always_comb begin
    more_after = 1'b0;
    for (int i = NUM_CODES - 1; i >= 1; i--) begin
      if (codes[CODE_W*i +: CODE_W] == CODE_RAW) more_after = 1'b0;
      else if (codes[CODE_W*i +: CODE_W] != CODE_NONE) more_after = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ended        <= 1'b0;
      left         <= '0;
      out_valid    <= 1'b0;
      missing_word <= '0;
    end else begin
      if (cfg_we) missing_word <= cfg_data;
      out_valid <= out_load || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready && !ended) begin
            if (left == '0) begin
              codes   <= in_word;
              left    <= POS_W'(NUM_CODES);
              state   <= S_WALK;
            end else begin
              // data word for a pending raw code
              out_word  <= in_word;
              item_kind <= 1'b0;
              last      <= !more_after;
              codes     <= codes >> CODE_W;
              left      <= left - 1'b1;
              if (left != POS_W'(1)) state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (code == CODE_RAW) begin
            // hold position until the data word arrives
            state <= S_IDLE;
          end else if (code == CODE_NONE) begin
            codes <= codes >> CODE_W;
            left  <= left - 1'b1;
            if (left == POS_W'(1)) state <= S_IDLE;
          end else if (out_free) begin
            case (code)
              CODE_END:     out_word <= '0;
              CODE_SPACES:  out_word <= SPACES_WORD;
              CODE_MISSING: out_word <= missing_word;
              default:      out_word <= code_to_double(code);
            endcase
            item_kind <= (code == CODE_END);
            if (code == CODE_END) begin
              ended <= 1'b1;
              last  <= 1'b1;
              left  <= '0;
              state <= S_IDLE;
            end else begin
              last  <= !more_after;
              codes <= codes >> CODE_W;
              left  <= left - 1'b1;
              if (left == POS_W'(1)) state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no input taken while a code walk is in progress
  assert property (@(posedge clk) disable iff (rst) (state == S_WALK) |-> !in_ready)
    else $error("input accepted during walk");
  // once ended, no new result is produced
  assert property (@(posedge clk) disable iff (rst)
    ($past(ended) && ended && !$past(out_valid)) |-> !out_valid)
    else $error("result after end marker");
  // a pending output is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_word) && out_valid))
    else $error("stalled result changed");
  // the end marker is always the last result
  assert property (@(posedge clk) disable iff (rst) (out_valid && item_kind) |-> last)
    else $error("end marker without last");

endmodule
